[src/change_point_group_sharpen_core_defines.svh]
// Assertion macros for the change point grouping core
`ifndef CHANGE_POINT_GROUP_SHARPEN_CORE_DEFINES_SVH
`define CHANGE_POINT_GROUP_SHARPEN_CORE_DEFINES_SVH

// same-cycle implication
`define CPGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cpgs_pkg.sv]
`default_nettype none

package cpgs_pkg;

  localparam int unsigned IdxW   = 32;
  localparam int unsigned WgtW   = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned ThrW   = 31;
  localparam int unsigned ReachW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  localparam logic [ThrW-1:0]   ThrReset   = ThrW'(6554);
  localparam logic [ReachW-1:0] ReachReset = ReachW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgReach     = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    KindPoint = 1'b0,
    KindEnd   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [ThrW-1:0]   threshold;
    logic [ReachW-1:0] reach;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [IdxW-1:0] position;
  } res_t;

  // up to three result words per item, packed from slot 0
  typedef struct packed {
    logic [1:0] num;
    res_t       slot0;
    res_t       slot1;
    res_t       slot2;
  } push_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
  } qstat_t;

endpackage

`default_nettype wire

[src/change_point_group_sharpen_core.sv]
// Channel | Dir | Handshake          | Word
// in      | in  | in_valid/in_stall  | point_index, jump_weight, last
// out     | out | out_valid/out_stall| kind, position
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input word per cycle unless the input stalls; results pass the input register, then the result queue.
// The group update and threshold compare sit between the input register
// and a four-word result queue; an item may yield up to three words.
// Input stalls while the input register holds an item and the queue lacks room for a three-word burst.
// Reset clears the group state and loads default threshold and reach.
`default_nettype none

module change_point_group_sharpen_core import cpgs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [IdxW-1:0]        point_index_i,
  input  wire logic signed [WgtW-1:0] jump_weight_i,
  input  wire logic                   last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        kind_o,
  output logic [IdxW-1:0]             position_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [CfgDataW-1:0]    cfg_data_i
);

  `include "change_point_group_sharpen_core_defines.svh"

  cfg_t                   cfg_q;
  logic                   stg_valid_q;
  logic [IdxW-1:0]        stg_idx_q;
  logic signed [WgtW-1:0] stg_wgt_q;
  logic                   stg_last_q;
  logic                   space, fire, take;
  push_t                  push;
  res_t                   head;
  qstat_t                 qstat;

  assign cfg_ready_o = 1'b1;
  assign fire        = stg_valid_q && space;
  assign in_stall_o  = stg_valid_q && !space;
  assign take        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThrReset;
      cfg_q.reach     <= ReachReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: cfg_q.threshold <= cfg_data_i[ThrW-1:0];
        CfgReach:     cfg_q.reach     <= cfg_data_i[ReachW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (take || fire) begin
      stg_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_idx_q  <= point_index_i;
      stg_wgt_q  <= jump_weight_i;
      stg_last_q <= last_i;
    end
  end

  cpgs_group u_group (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (fire),
    .idx_i  (stg_idx_q),
    .wgt_i  (stg_wgt_q),
    .last_i (stg_last_q),
    .push_o (push)
  );

  cpgs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head),
    .stat_o  (qstat)
  );

  assign kind_o     = head.kind;
  assign position_o = head.position;

  `CPGS_ASSERT_NOW(a_stall_needs_item, in_stall_o, stg_valid_q, "input stalled with empty stage")
  `CPGS_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= QCntW'(QDepth), "result queue overrun")
  `CPGS_ASSERT_NEXT(a_last_emits, fire && stg_last_q, out_valid_o, "end marker not queued")
  `CPGS_ASSERT_NOW(a_push_fits, fire, space, "burst pushed without room")

endmodule

`default_nettype wire

[src/cpgs_group.sv]
`default_nettype none

module cpgs_group import cpgs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   fire_i,
  input  wire logic [IdxW-1:0]        idx_i,
  input  wire logic signed [WgtW-1:0] wgt_i,
  input  wire logic                   last_i,
  output push_t                       push_o
);

  logic                   open_q, open_d;
  logic [IdxW-1:0]        prev_q, prev_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [WgtW-1:0]        bmag_q, bmag_d;
  logic [IdxW-1:0]        bidx_q, bidx_d;

  logic [IdxW-1:0]        gap;
  logic                   link, joined, close_a, keep_a, keep_b;
  logic [WgtW-1:0]        wmag;
  logic signed [SumW:0]   sum_ext;
  logic [SumW-1:0]        smag_old, smag_new;
  res_t                   res_a, res_b, res_e;

  always_comb begin
    gap     = idx_i - prev_q;
    link    = gap[IdxW-1] || (gap < IdxW'(cfg_i.reach));
    joined  = open_q && link;
    close_a = open_q && !link;
    wmag    = wgt_i[WgtW-1] ? (~wgt_i + WgtW'(1)) : wgt_i;

    sum_ext = {sum_q[SumW-1], sum_q} + (SumW+1)'(wgt_i);
    if (!joined) begin
      sum_d = SumW'(wgt_i);
    end else if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_d = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_d = sum_ext[SumW-1:0];
    end

    if (!joined || (wmag > bmag_q)) begin
      bmag_d = wmag;
      bidx_d = idx_i;
    end else begin
      bmag_d = bmag_q;
      bidx_d = bidx_q;
    end

    smag_old = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;
    smag_new = sum_d[SumW-1] ? (~sum_d + SumW'(1)) : sum_d;
    keep_a   = close_a && (smag_old > SumW'(cfg_i.threshold));
    keep_b   = last_i && (smag_new > SumW'(cfg_i.threshold));

    open_d = !last_i;
    prev_d = idx_i;

    res_a.kind     = KindPoint;
    res_a.position = bidx_q + IdxW'(1);
    res_b.kind     = KindPoint;
    res_b.position = bidx_d + IdxW'(1);
    res_e.kind     = KindEnd;
    res_e.position = '0;

    push_o.num   = fire_i ? (2'(keep_a) + 2'(keep_b) + 2'(last_i)) : 2'd0;
    push_o.slot0 = keep_a ? res_a : (keep_b ? res_b : res_e);
    push_o.slot1 = (keep_a && keep_b) ? res_b : res_e;
    push_o.slot2 = res_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      prev_q <= '0;
      sum_q  <= '0;
      bmag_q <= '0;
      bidx_q <= '0;
    end else if (fire_i) begin
      open_q <= open_d;
      prev_q <= prev_d;
      sum_q  <= sum_d;
      bmag_q <= bmag_d;
      bidx_q <= bidx_d;
    end
  end

endmodule

`default_nettype wire

[src/cpgs_fifo.sv]
`default_nettype none

module cpgs_fifo import cpgs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       space_o,
  output logic       valid_o,
  input  wire logic  stall_i,
  output res_t       head_o,
  output qstat_t     stat_o
);

  res_t             buf_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;
  res_t             slots [3];

  assign slots[0] = push_i.slot0;
  assign slots[1] = push_i.slot1;
  assign slots[2] = push_i.slot2;

  assign valid_o      = (cnt_q != '0);
  assign pop          = valid_o && !stall_i;
  assign head_o       = buf_q[rd_q];
  assign stat_o.count = cnt_q;
  // room for a full three-word burst after this cycle's pop
  assign space_o = (cnt_q <= QCntW'(QDepth - 3)) ||
                   (pop && (cnt_q == QCntW'(QDepth - 2)));

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_i.num) begin
        buf_q[wr_q + QPtrW'(k)] <= slots[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.num);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + QCntW'(push_i.num) - QCntW'(pop);
    end
  end

endmodule

`default_nettype wire

[tb/cpgs_point_check.sv]
`default_nettype none

module cpgs_point_check import cpgs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic [IdxW-1:0]      point_index_i,
  input  wire logic [WgtW-1:0]      jump_weight_i,
  input  wire logic                 last_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic                 kind_i,
  input  wire logic [IdxW-1:0]      position_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  output int                        pending_o,
  output int                        mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SumHi = (longint'(1) <<< 47) - 1;
  localparam longint SumLo = -SumHi - 1;

  logic [ThrW-1:0]   thr;
  logic [ReachW-1:0] reach;

  bit                grp_open;
  logic [IdxW-1:0]   prev_idx;
  longint            run_sum;
  longint unsigned   peak_mag;
  logic [IdxW-1:0]   peak_idx;

  res_t kept_q[$];
  int   errs;

  function automatic longint unsigned mag_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic close_group();
    grp_open = 1'b0;
    if (mag_of(run_sum) > thr) kept_q.push_back('{kind: KindPoint, position: peak_idx + 1'b1});
  endtask

  task automatic open_group(input logic [IdxW-1:0] idx, input longint w);
    grp_open = 1'b1;
    run_sum  = w;
    peak_mag = mag_of(w);
    peak_idx = idx;
  endtask

  // group update for one accepted word
  task automatic take_point(input logic [IdxW-1:0] idx, input logic signed [WgtW-1:0] wgt,
                            input bit lst);
    logic [IdxW-1:0] gap;
    longint          w;
    longint          s;
    w = longint'(wgt);
    if (grp_open) begin
      gap = idx - prev_idx;
      if (longint'($signed(gap)) < longint'(reach)) begin
        s = run_sum + w;
        if (s > SumHi) s = SumHi;
        if (s < SumLo) s = SumLo;
        run_sum = s;
        if (mag_of(w) > peak_mag) begin
          peak_mag = mag_of(w);
          peak_idx = idx;
        end
      end else begin
        close_group();
        open_group(idx, w);
      end
    end else begin
      open_group(idx, w);
    end
    prev_idx = idx;
    if (lst) begin
      close_group();
      kept_q.push_back('{kind: KindEnd, position: '0});
    end
  endtask

  task automatic flag_word(input string why, input res_t want);
    errs++;
    if (errs <= 10)
      $display("%s: expected kind %0d position %h, got kind %0d position %h",
               why, want.kind, want.position, kind_i, position_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      thr          = ThrReset;
      reach        = ReachReset;
      grp_open     = 1'b0;
      prev_idx     = '0;
      run_sum      = 0;
      peak_mag     = 0;
      peak_idx     = '0;
      errs         = 0;
      kept_q.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (kept_q.size() == 0) begin
          flag_word("unexpected word", '0);
        end else begin
          want = kept_q.pop_front();
          if (kind_i !== want.kind || position_i !== want.position)
            flag_word("wrong word", want);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgThreshold: thr = cfg_data_i[ThrW-1:0];
          CfgReach:     reach = cfg_data_i[ReachW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_point(point_index_i, jump_weight_i, last_i);
      pending_o    <= kept_q.size();
      mismatches_o <= errs;
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
  import cpgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 1_500_000;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned Phases       = 6;
  localparam int unsigned PhaseItems   = 64;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [IdxW-1:0]     point_index_i = '0;
  logic [WgtW-1:0]     jump_weight_i = '0;
  logic                last_i        = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                kind_o;
  logic [IdxW-1:0]     position_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int              pending;
  int              mismatches;
  int unsigned     cycles = 0;
  bit              src_jitter  = 1'b0;
  bit              sink_jitter = 1'b0;
  bit              hold_req    = 1'b0;
  logic [IdxW-1:0] prev_sent   = '0;

  always #5ns clk_i = ~clk_i;

  change_point_group_sharpen_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_index_i (point_index_i),
    .jump_weight_i (jump_weight_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .position_o    (position_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  cpgs_point_check point_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .point_index_i (point_index_i),
    .jump_weight_i (jump_weight_i),
    .last_i        (last_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .position_i    (position_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .mismatches_o  (mismatches)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL change_point_group_sharpen_core");
      $finish;
    end
  end

  // result side: long hold on request, otherwise random stall bursts while sink jitter is on
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall_i <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_point(input logic [IdxW-1:0] idx, input logic [WgtW-1:0] wgt,
                            input bit lst);
    if (src_jitter && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    point_index_i <= idx;
    jump_weight_i <= wgt;
    last_i        <= lst;
    do @(posedge clk_i); while (in_stall_o);
    prev_sent = idx;
  endtask

  // wait until every expected word is out and the pipe has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e which, input logic [CfgDataW-1:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_point(input int unsigned reach_now, input int unsigned last_odds);
    logic [IdxW-1:0] idx;
    logic [WgtW-1:0] wgt;
    int unsigned     pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) idx = $urandom_range(0, 32'hFFFF_FFFE);
    else if (pick == 1) idx = prev_sent - $urandom_range(1, 20);
    else idx = prev_sent + $urandom_range(0, 2 * reach_now + 1);
    if (idx == '1) idx = '0;
    case ($urandom_range(0, 4))
      0, 1: wgt = $urandom();
      2: wgt = $urandom_range(0, 32'h3FFFF) - 32'h20000;
      3: begin
        case ($urandom_range(0, 3))
          0: wgt = 32'h7FFF_FFFF;
          1: wgt = 32'h8000_0000;
          2: wgt = '0;
          default: wgt = '1;
        endcase
      end
      default: begin
        wgt = $urandom_range(0, 32'h1FFFF);
        if ($urandom_range(0, 1) == 1) wgt = -wgt;
      end
    endcase
    send_point(idx, wgt, $urandom_range(1, last_odds) == 1);
  endtask

  initial begin
    logic [ThrW-1:0]   thr_set[Phases];
    logic [ReachW-1:0] reach_set[Phases];
    int unsigned       k;
    thr_set   = '{31'd0, 31'h0000_8000, 31'h7FFF_FFFF, 31'($urandom_range(0, 32'h30000)),
                  31'd6554, 31'($urandom_range(1, 32'h7FFF_FFFF))};
    reach_set = '{16'd1, 16'd65535, 16'd10, 16'($urandom_range(1, 64)), 16'd3,
                  16'($urandom_range(1, 65535))};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_jitter  = 1'b1;
    sink_jitter = 1'b1;

    // default threshold and reach
    send_point(32'd0,          32'h0001_0000, 1'b0);
    send_point(32'd5,          32'hFFFF_8000, 1'b0);
    send_point(32'd15,         32'h7FFF_FFFF, 1'b0);
    send_point(32'd16,         32'h8000_0000, 1'b0);
    send_point(32'd10,         32'h8000_0000, 1'b0);  // backward gap, magnitude tie
    send_point(32'd20,         32'h0000_0001, 1'b1);  // closes a kept group, then the end marker: two words
    send_point(32'hFFFF_FFFC,  32'h0002_0000, 1'b0);
    send_point(32'hFFFF_FFFE,  32'hFFFE_0000, 1'b0);
    send_point(32'd3,          32'h0003_0000, 1'b0);  // gap across index wrap
    send_point(32'd3,          32'h0000_0000, 1'b1);
    send_point(32'hFFFF_FFFE,  32'h4000_0000, 1'b1);
    send_point(32'd100,        32'd6554,      1'b1);  // sum equal to threshold
    send_point(32'd200,        32'd6555,      1'b1);
    send_point(32'd300,        32'hFFFF_E666, 1'b1);
    send_point(32'd400,        32'h0000_0000, 1'b0);
    send_point(32'd409,        32'h0000_0000, 1'b0);
    send_point(32'd419,        32'h0000_0000, 1'b1);

    // zero reach: only backward steps link
    write_reg(CfgReach, 32'd0);
    write_reg(CfgThreshold, 32'd0);
    send_point(32'd50, 32'h0000_0001, 1'b0);
    send_point(32'd50, 32'h0000_0000, 1'b0);
    send_point(32'd40, 32'h0000_0000, 1'b0);
    send_point(32'd41, 32'h0000_0000, 1'b1);

    write_reg(CfgThreshold, 32'h7FFF_FFFF);
    write_reg(CfgReach, 32'd65535);
    send_point(32'd1000,   32'h7FFF_FFFF, 1'b0);
    send_point(32'd66534,  32'h7FFF_FFFF, 1'b0);
    send_point(32'd132069, 32'h0000_0001, 1'b1);

    for (int ph = 0; ph < Phases; ph++) begin
      write_reg(CfgThreshold, 32'(thr_set[ph]));
      write_reg(CfgReach, 32'(reach_set[ph]));
      src_jitter  = (ph != 2 && ph != Phases - 1);
      sink_jitter = (ph != 4 && ph != Phases - 1);
      for (k = 0; k < PhaseItems; k++) begin
        if (ph == 1 && k == 10) hold_req = 1'b1;
        if (ph == 1 && k == 40) settle();
        random_point(reach_set[ph], (ph == 1 && k < 40) ? 3 : 12);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS change_point_group_sharpen_core");
    end else begin
      $display("FAIL change_point_group_sharpen_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/cpgs_pkg.sv
src/cpgs_group.sv
src/cpgs_fifo.sv
src/change_point_group_sharpen_core.sv
tb/cpgs_point_check.sv
tb/tb_top.sv
